/* rtl/core/sector_cache_lru_directory_macros.svh */
// Assertion macros used by the checker module.
`ifndef SECTOR_CACHE_LRU_DIRECTORY_MACROS_SVH
`define SECTOR_CACHE_LRU_DIRECTORY_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SCLRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sclru check failed");

// Next-cycle implication, disabled while in reset.
`define SCLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sclru check failed");

`endif

/* rtl/core/sclru_pkg.sv */
package sclru_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int SECTOR_W = 32;
    localparam int AGE_W    = 32;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;
    localparam int COUNT_W  = 3;
    localparam int EIDX_W   = 4;

    localparam logic [SECTOR_W-1:0] LBA28_LIMIT = 32'h0FFF_FFFF;
    localparam logic [SECTOR_W-1:0] INVALID_TAG = '1;

    // Register select is paddr[2]
    localparam logic REG_LBA48 = 1'b0;
    localparam logic REG_PHYS  = 1'b1;

    localparam logic [1:0] LOG2_MAX = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_FILL     = 2'd1,
        ST_UNCACHED = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    function automatic logic [EIDX_W-1:0] to_entry_index(input idx_t idx);
        logic [IDX_W+EIDX_W-1:0] wide;
        wide = {{EIDX_W{1'b0}}, idx};
        return wide[EIDX_W-1:0];
    endfunction

endpackage

/* rtl/core/sclru_if.sv */
interface sclru_req_if;
    import sclru_pkg::*;
    logic                valid;
    logic                ready;
    logic [SECTOR_W-1:0] sector;
    logic                use_cache;
    modport source (output valid, sector, use_cache, input ready);
    modport sink   (input valid, sector, use_cache, output ready);
endinterface

interface sclru_rsp_if;
    import sclru_pkg::*;
    logic                valid;
    logic                ready;
    status_t             status;
    logic [SECTOR_W-1:0] block_sector;
    logic [SECTOR_W-1:0] read_start;
    logic [COUNT_W-1:0]  read_count;
    logic [EIDX_W-1:0]   entry_index;
    logic                is_requested;
    logic                last;
    modport source (output valid, status, block_sector, read_start, read_count,
                    entry_index, is_requested, last, input ready);
    modport sink   (input valid, status, block_sector, read_start, read_count,
                    entry_index, is_requested, last, output ready);
endinterface

/* rtl/core/sector_cache_lru_directory.sv */
// Channel | Dir | Transfer when      | Payload
// req     | in  | valid && ready     | sector, use_cache
// rsp     | out | valid && ready     | status, block_sector, read_start, read_count,
//         |     |                    | entry_index, is_requested, last
// apb     | in  | psel&penable&pwrite| lba48_mode at 0x0, phys_blocks_log2 at 0x4
//
// One request at a time; a single compare unit walks the directory one entry a cycle.
// A cached request scans the whole directory, then each block of a cached read is scanned again
// before its fill; an uncached request goes straight to its decision and fills without scans.
// Reset (rst_n low, asynchronous) clears the directory: tags all ones, ages zero.
// A stalled rsp holds the sequencer at its next result; req is taken once the last
// result sits in the output register.
module sector_cache_lru_directory (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sclru_pkg::ADDR_W-1:0]    paddr,
    input  logic [sclru_pkg::DATA_W-1:0]    pwdata,
    output logic [sclru_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    sclru_req_if.sink                       req,
    sclru_rsp_if.source                     rsp
);
    import sclru_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_FILL   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic                lba48_reg;
    logic [1:0]          phys_log2_reg;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic                cached_reg, cached_next;
    logic                phase_req_reg, phase_req_next;
    logic [SECTOR_W-1:0] key_reg, key_next;
    idx_t                scan_idx_reg, scan_idx_next;
    logic                found_reg, found_next;
    idx_t                hit_idx_reg, hit_idx_next;
    idx_t                min_idx_reg, min_idx_next;
    logic [AGE_W-1:0]    min_age_reg, min_age_next;
    logic [SECTOR_W-1:0] start_reg, start_next;
    logic [COUNT_W-1:0]  size_reg, size_next;
    logic [1:0]          k_reg, k_next;
    logic [SECTOR_W-1:0] blk_reg, blk_next;
    logic [AGE_W-1:0]    age_clock_reg, age_clock_next;
    logic [SECTOR_W-1:0] tags_reg [ENTRIES];
    logic [AGE_W-1:0]    ages_reg [ENTRIES];

    logic                rsp_valid_reg, rsp_valid_next;
    status_t             status_reg, status_next;
    logic [SECTOR_W-1:0] bsec_reg, bsec_next;
    logic [SECTOR_W-1:0] rstart_reg, rstart_next;
    logic [COUNT_W-1:0]  rcount_reg, rcount_next;
    logic [EIDX_W-1:0]   eidx_reg, eidx_next;
    logic                isreq_reg, isreq_next;
    logic                last_reg, last_next;

    logic                tag_we, age_we;
    idx_t                w_idx;
    logic [SECTOR_W-1:0] w_tag;
    logic [AGE_W-1:0]    w_age;

    logic                cfg_write;
    logic                slot_free;
    logic [SECTOR_W-1:0] tag_i;
    logic [AGE_W-1:0]    age_i;
    logic                match;
    logic                take_min;
    logic                scan_end;
    logic [1:0]          lg;
    logic [1:0]          eff_lg;
    logic [COUNT_W-1:0]  req_size;
    logic [COUNT_W-1:0]  req_mask;
    logic [SECTOR_W-1:0] req_start;
    logic                out_of_range;
    logic                blk_last;
    idx_t                fill_idx;
    logic [AGE_W-1:0]    fill_age;

    function automatic logic [1:0] req_mask_of(input logic [COUNT_W-1:0] size);
        logic [COUNT_W-1:0] m;
        m = size - COUNT_W'(1);
        return m[1:0];
    endfunction

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lba48_reg     <= 1'b0;
            phys_log2_reg <= 2'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_LBA48: lba48_reg     <= pwdata[0];
                REG_PHYS:  phys_log2_reg <= pwdata[1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_LBA48: prdata = {{(DATA_W-1){1'b0}}, lba48_reg};
            REG_PHYS:  prdata = {{(DATA_W-2){1'b0}}, phys_log2_reg};
            default:   prdata = '0;
        endcase
    end

    // Shared compare unit over one directory entry
    assign tag_i    = tags_reg[scan_idx_reg];
    assign age_i    = ages_reg[scan_idx_reg];
    assign match    = !found_reg && (key_reg != INVALID_TAG) && (tag_i == key_reg);
    assign take_min = (scan_idx_reg == '0) || (age_i < min_age_reg);
    assign scan_end = (scan_idx_reg == IDX_W'(ENTRIES - 1));

    // Read alignment; an unused log2 code counts as four blocks
    assign lg           = (phys_log2_reg > LOG2_MAX) ? LOG2_MAX : phys_log2_reg;
    assign eff_lg       = cached_reg ? LOG2_MAX : lg;
    assign req_size     = COUNT_W'(1) << eff_lg;
    assign req_mask     = req_size - COUNT_W'(1);
    assign req_start    = {sector_reg[SECTOR_W-1:2], sector_reg[1:0] & ~req_mask[1:0]};
    assign out_of_range = !lba48_reg && (sector_reg > LBA28_LIMIT);

    assign blk_last = (k_reg == req_mask_of(size_reg));
    assign fill_idx = found_reg ? hit_idx_reg : min_idx_reg;
    assign fill_age = found_reg ? age_clock_reg + AGE_W'(1) : age_clock_reg;

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        sector_next    = sector_reg;
        cached_next    = cached_reg;
        phase_req_next = phase_req_reg;
        key_next       = key_reg;
        scan_idx_next  = scan_idx_reg;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        min_idx_next   = min_idx_reg;
        min_age_next   = min_age_reg;
        start_next     = start_reg;
        size_next      = size_reg;
        k_next         = k_reg;
        blk_next       = blk_reg;
        age_clock_next = age_clock_reg;
        tag_we         = 1'b0;
        age_we         = 1'b0;
        w_idx          = fill_idx;
        w_tag          = blk_reg;
        w_age          = fill_age;
        rsp_valid_next = rsp.ready ? 1'b0 : rsp_valid_reg;
        status_next    = status_reg;
        bsec_next      = bsec_reg;
        rstart_next    = rstart_reg;
        rcount_next    = rcount_reg;
        eidx_next      = eidx_reg;
        isreq_next     = isreq_reg;
        last_next      = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    sector_next    = req.sector;
                    cached_next    = req.use_cache;
                    key_next       = req.sector;
                    phase_req_next = 1'b1;
                    scan_idx_next  = '0;
                    found_next     = 1'b0;
                    state_next     = req.use_cache ? S_SCAN : S_DECIDE;
                end
            end

            S_SCAN:
            begin
                if (match)
                begin
                    found_next   = 1'b1;
                    hit_idx_next = scan_idx_reg;
                end
                if (take_min)
                begin
                    min_idx_next = scan_idx_reg;
                    min_age_next = age_i;
                end
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_end)
                    state_next = phase_req_reg ? S_DECIDE : S_FILL;
            end

            S_DECIDE:
            begin
                if (found_reg)
                begin
                    if (slot_free)
                    begin
                        age_clock_next = age_clock_reg + AGE_W'(1);
                        age_we         = 1'b1;
                        w_idx          = hit_idx_reg;
                        w_age          = age_clock_reg + AGE_W'(1);
                        rsp_valid_next = 1'b1;
                        status_next    = ST_HIT;
                        bsec_next      = sector_reg;
                        rstart_next    = '0;
                        rcount_next    = '0;
                        eidx_next      = to_entry_index(hit_idx_reg);
                        isreq_next     = 1'b1;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (out_of_range)
                begin
                    if (slot_free)
                    begin
                        rsp_valid_next = 1'b1;
                        status_next    = ST_RANGE;
                        bsec_next      = sector_reg;
                        rstart_next    = '0;
                        rcount_next    = '0;
                        eidx_next      = '0;
                        isreq_next     = 1'b1;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    start_next     = req_start;
                    size_next      = req_size;
                    k_next         = 2'd0;
                    blk_next       = req_start;
                    key_next       = req_start;
                    phase_req_next = 1'b0;
                    scan_idx_next  = '0;
                    found_next     = 1'b0;
                    state_next     = cached_reg ? S_SCAN : S_FILL;
                end
            end

            S_FILL:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    bsec_next      = blk_reg;
                    rstart_next    = start_reg;
                    rcount_next    = size_reg;
                    isreq_next     = (blk_reg == sector_reg);
                    last_next      = blk_last;
                    if (cached_reg)
                    begin
                        tag_we         = 1'b1;
                        age_we         = 1'b1;
                        // Age clock steps once more after the final block
                        age_clock_next = blk_last ? fill_age + AGE_W'(1) : fill_age;
                        status_next    = ST_FILL;
                        eidx_next      = to_entry_index(fill_idx);
                    end
                    else
                    begin
                        status_next = ST_UNCACHED;
                        eidx_next   = '0;
                    end
                    if (blk_last)
                        state_next = S_IDLE;
                    else
                    begin
                        k_next        = k_reg + 2'd1;
                        blk_next      = blk_reg + SECTOR_W'(1);
                        key_next      = blk_reg + SECTOR_W'(1);
                        scan_idx_next = '0;
                        found_next    = 1'b0;
                        if (cached_reg)
                            state_next = S_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_req_reg <= 1'b0;
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            k_reg         <= 2'd0;
            age_clock_reg <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                tags_reg[i] <= INVALID_TAG;
                ages_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_req_reg <= phase_req_next;
            scan_idx_reg  <= scan_idx_next;
            found_reg     <= found_next;
            k_reg         <= k_next;
            age_clock_reg <= age_clock_next;
            rsp_valid_reg <= rsp_valid_next;
            if (tag_we)
                tags_reg[w_idx] <= w_tag;
            if (age_we)
                ages_reg[w_idx] <= w_age;
        end
    end

    always_ff @(posedge clk)
    begin
        sector_reg  <= sector_next;
        cached_reg  <= cached_next;
        key_reg     <= key_next;
        hit_idx_reg <= hit_idx_next;
        min_idx_reg <= min_idx_next;
        min_age_reg <= min_age_next;
        start_reg   <= start_next;
        size_reg    <= size_next;
        blk_reg     <= blk_next;
        status_reg  <= status_next;
        bsec_reg    <= bsec_next;
        rstart_reg  <= rstart_next;
        rcount_reg  <= rcount_next;
        eidx_reg    <= eidx_next;
        isreq_reg   <= isreq_next;
        last_reg    <= last_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.block_sector = bsec_reg;
    assign rsp.read_start   = rstart_reg;
    assign rsp.read_count   = rcount_reg;
    assign rsp.entry_index  = eidx_reg;
    assign rsp.is_requested = isreq_reg;
    assign rsp.last         = last_reg;

endmodule

/* rtl/core/sclru_checker.sv */
`include "sector_cache_lru_directory_macros.svh"

module sclru_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input sclru_pkg::status_t               rsp_status,
    input logic [sclru_pkg::SECTOR_W-1:0]   rsp_block_sector,
    input logic [sclru_pkg::SECTOR_W-1:0]   rsp_read_start,
    input logic [sclru_pkg::COUNT_W-1:0]    rsp_read_count,
    input logic [sclru_pkg::EIDX_W-1:0]     rsp_entry_index,
    input logic                             rsp_is_requested,
    input logic                             rsp_last
);
    import sclru_pkg::*;

    logic [2*SECTOR_W+COUNT_W+EIDX_W+3:0] rsp_bits;
    logic                                 rsp_stall;
    logic                                 single_result;
    logic                                 single_ok;

    assign rsp_bits = {rsp_status, rsp_block_sector, rsp_read_start, rsp_read_count,
                       rsp_entry_index, rsp_is_requested, rsp_last};
    assign rsp_stall     = rsp_valid && !rsp_ready;
    assign single_result = rsp_valid && (rsp_status == ST_HIT || rsp_status == ST_RANGE);
    assign single_ok     = rsp_last && rsp_is_requested && (rsp_read_count == '0);

    // Hold a stalled result
    `SCLRU_ASSERT_NEXT(a_rsp_valid_hold, clk, rst_n, rsp_stall, rsp_valid)
    `SCLRU_ASSERT_NEXT(a_rsp_bits_hold, clk, rst_n, rsp_stall, $stable(rsp_bits))

    // A hit or range error is a lone result with no device read
    `SCLRU_ASSERT_NOW(a_single_result, clk, rst_n, single_result, single_ok)

    // No new request while the current one still has results to give
    `SCLRU_ASSERT_NOW(a_busy_mid_read, clk, rst_n, rsp_valid && !rsp_last, !req_ready)

    // Drop ready after taking a request
    `SCLRU_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)

endmodule

bind sector_cache_lru_directory sclru_checker u_sclru_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_block_sector (rsp.block_sector),
    .rsp_read_start   (rsp.read_start),
    .rsp_read_count   (rsp.read_count),
    .rsp_entry_index  (rsp.entry_index),
    .rsp_is_requested (rsp.is_requested),
    .rsp_last         (rsp.last)
);
